[hw/rtl/assert_macros.svh]
// Assertion helpers for clocked properties with an active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define SGS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define SGS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/sgs_pkg.sv]
package sgs_pkg;

	localparam int PATTERN_MAX_DEF = 64;
	localparam int HAYSTACK_MAX    = 4096;
	localparam int CHAR_W          = 16;
	localparam int IDX_W           = 6;
	localparam int LEN_W           = 7;
	localparam int POS_W           = 12;
	localparam int HPOS_W          = 13;
	localparam int GAP_W           = 12;
	localparam logic [GAP_W-1:0] GAP_CAP = '1;
	localparam int OUT_DEPTH       = 4;
	localparam int OUT_PTR_W       = 2;
	localparam int OUT_CNT_W       = 3;

	typedef enum logic {
		KIND_LOAD     = 1'b0,
		KIND_HAYSTACK = 1'b1
	} in_kind_t;

	typedef enum logic {
		RES_MATCH = 1'b0,
		RES_FINAL = 1'b1
	} res_kind_t;

	typedef struct packed {
		in_kind_t          kind;
		logic [IDX_W-1:0]  pattern_index;
		logic [CHAR_W-1:0] char_code;
		logic              haystack_last;
	} in_item_t;

	typedef struct packed {
		res_kind_t                result_kind;
		logic [POS_W-1:0]         match_position;
		logic signed [HPOS_W-1:0] score;
		logic signed [HPOS_W-1:0] first_position;
		logic [HPOS_W-1:0]        end_position;
		logic                     overflow;
		logic                     run_last;
	} res_t;

endpackage

[hw/rtl/subsequence_gap_scorer_top.sv]
// Flow: a request is registered at acceptance and is scored from that register once
// the output queue has room; the queue then offers its results from its registers.
// Throughput: one request per cycle while the four-entry output queue holds at most two
// results; a match on the final haystack character yields two results, which leave
// one per cycle while out_ready is high.
// Reset: arst_n clears the pattern length, the match state and the queue at once;
// the pattern store keeps no reset and must be loaded before use.
module subsequence_gap_scorer_top #(
	parameter int PATTERN_MAX = sgs_pkg::PATTERN_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sgs_pkg::LEN_W-1:0]           cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic [sgs_pkg::IDX_W-1:0]           pattern_index,
	input  logic [sgs_pkg::CHAR_W-1:0]          char_code,
	input  logic                                haystack_last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                result_kind,
	output logic [sgs_pkg::POS_W-1:0]           match_position,
	output logic signed [sgs_pkg::HPOS_W-1:0]   score,
	output logic signed [sgs_pkg::HPOS_W-1:0]   first_position,
	output logic [sgs_pkg::HPOS_W-1:0]          end_position,
	output logic                                overflow,
	output logic                                run_last
);

	localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	sgs_pkg::in_item_t           item_s1;
	logic                        valid_s1;
	logic                        proc;
	logic                        room;
	logic                        st_we;
	logic [AW-1:0]               st_waddr, st_raddr;
	logic [sgs_pkg::CHAR_W-1:0]  cur_char;
	logic [1:0]                  push_cnt;
	sgs_pkg::res_t               res0, res1, head;

	assign proc     = valid_s1 && room;
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind          <= sgs_pkg::in_kind_t'(kind);
			item_s1.pattern_index <= pattern_index;
			item_s1.char_code     <= char_code;
			item_s1.haystack_last <= haystack_last;
		end
	end

	sgs_store #(
		.PATTERN_MAX(PATTERN_MAX),
		.AW(AW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (item_s1.char_code),
		.raddr (st_raddr),
		.rdata (cur_char)
	);

	sgs_core #(
		.PATTERN_MAX(PATTERN_MAX),
		.AW(AW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.proc      (proc),
		.item      (item_s1),
		.cur_char  (cur_char),
		.st_we     (st_we),
		.st_waddr  (st_waddr),
		.st_raddr  (st_raddr),
		.push_cnt  (push_cnt),
		.res0      (res0),
		.res1      (res1)
	);

	sgs_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.d0        (res0),
		.d1        (res1),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign result_kind    = head.result_kind;
	assign match_position = head.match_position;
	assign score          = head.score;
	assign first_position = head.first_position;
	assign end_position   = head.end_position;
	assign overflow       = head.overflow;
	assign run_last       = head.run_last;

endmodule

[hw/rtl/sgs_store.sv]
module sgs_store #(
	parameter int PATTERN_MAX = sgs_pkg::PATTERN_MAX_DEF,
	parameter int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [sgs_pkg::CHAR_W-1:0]  wdata,
	input  logic [AW-1:0]               raddr,
	output logic [sgs_pkg::CHAR_W-1:0]  rdata
);

	logic [sgs_pkg::CHAR_W-1:0] mem [PATTERN_MAX];
	logic [sgs_pkg::CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// forward a write to the slot being fetched
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/sgs_core.sv]
module sgs_core #(
	parameter int PATTERN_MAX = sgs_pkg::PATTERN_MAX_DEF,
	parameter int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
	parameter int PW = $clog2(PATTERN_MAX + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sgs_pkg::LEN_W-1:0]   cfg_wdata,
	input  logic                        proc,
	input  sgs_pkg::in_item_t           item,
	input  logic [sgs_pkg::CHAR_W-1:0]  cur_char,
	output logic                        st_we,
	output logic [AW-1:0]               st_waddr,
	output logic [AW-1:0]               st_raddr,
	output logic [1:0]                  push_cnt,
	output sgs_pkg::res_t               res0,
	output sgs_pkg::res_t               res1
);

	logic [sgs_pkg::LEN_W-1:0]          pattern_len_q;
	logic [PW-1:0]                      pattern_pos_q, pattern_pos_n;
	logic [sgs_pkg::HPOS_W-1:0]         haystack_pos_q, haystack_pos_n;
	logic [sgs_pkg::GAP_W-1:0]          gap_sum_q, gap_sum_n;
	logic [sgs_pkg::HPOS_W-1:0]         last_end_q, last_end_n;
	logic signed [sgs_pkg::HPOS_W-1:0]  first_seen_q, first_seen_n;
	logic                               too_long_q, too_long_n;

	logic [PW-1:0]                      len;
	logic                               is_hay;
	logic                               hs_over;
	logic                               hit;
	logic                               done;
	logic [sgs_pkg::POS_W-1:0]          p;
	logic [sgs_pkg::HPOS_W-1:0]         gap;
	logic [sgs_pkg::GAP_W+1:0]          gap_tot;
	sgs_pkg::res_t                      ev_match, ev_final;

	always_comb begin
		if (32'(pattern_len_q) > PATTERN_MAX) begin
			len = PW'(PATTERN_MAX);
		end else begin
			len = PW'(pattern_len_q);
		end
	end

	assign is_hay  = (item.kind == sgs_pkg::KIND_HAYSTACK);
	assign hs_over = (haystack_pos_q == sgs_pkg::HPOS_W'(sgs_pkg::HAYSTACK_MAX));
	assign p       = haystack_pos_q[sgs_pkg::POS_W-1:0];
	assign hit     = is_hay && !hs_over && (pattern_pos_q < len) &&
	                 (cur_char == item.char_code);
	assign gap     = {1'b0, p} - last_end_q;
	assign gap_tot = (sgs_pkg::GAP_W+2)'(gap_sum_q) + (sgs_pkg::GAP_W+2)'(gap);

	always_comb begin
		pattern_pos_n  = pattern_pos_q;
		haystack_pos_n = haystack_pos_q;
		gap_sum_n      = gap_sum_q;
		last_end_n     = last_end_q;
		first_seen_n   = first_seen_q;
		too_long_n     = too_long_q;
		if (is_hay) begin
			if (hs_over) begin
				too_long_n = 1'b1;
			end else begin
				haystack_pos_n = haystack_pos_q + 1'b1;
				if (hit) begin
					if (gap_tot > (sgs_pkg::GAP_W+2)'(sgs_pkg::GAP_CAP)) begin
						gap_sum_n = sgs_pkg::GAP_CAP;
					end else begin
						gap_sum_n = gap_tot[sgs_pkg::GAP_W-1:0];
					end
					if (first_seen_q[sgs_pkg::HPOS_W-1]) begin
						first_seen_n = $signed({1'b0, p});
					end
					last_end_n    = {1'b0, p} + 1'b1;
					pattern_pos_n = pattern_pos_q + 1'b1;
				end
			end
		end
	end

	assign done = (pattern_pos_n >= len);

	always_comb begin
		ev_match                = '0;
		ev_match.result_kind    = sgs_pkg::RES_MATCH;
		ev_match.match_position = p;
		ev_match.overflow       = too_long_n;
		ev_match.run_last       = !item.haystack_last;

		ev_final             = '0;
		ev_final.result_kind = sgs_pkg::RES_FINAL;
		ev_final.overflow    = too_long_n;
		ev_final.run_last    = 1'b1;
		if (done) begin
			ev_final.score          = $signed({1'b0, gap_sum_n});
			ev_final.first_position = first_seen_n;
			ev_final.end_position   = last_end_n;
		end else begin
			ev_final.score          = '1;
			ev_final.first_position = '1;
			ev_final.end_position   = '0;
		end
	end

	always_comb begin
		push_cnt = 2'd0;
		res0     = ev_final;
		res1     = ev_final;
		if (proc && is_hay) begin
			if (hit) begin
				res0     = ev_match;
				push_cnt = item.haystack_last ? 2'd2 : 2'd1;
			end else if (item.haystack_last) begin
				push_cnt = 2'd1;
			end
		end
	end

	assign st_we    = proc && !is_hay && (32'(item.pattern_index) < PATTERN_MAX);
	assign st_waddr = AW'(item.pattern_index);

	always_comb begin
		if (proc && is_hay && item.haystack_last) begin
			st_raddr = '0;
		end else if (proc) begin
			st_raddr = AW'(pattern_pos_n);
		end else begin
			st_raddr = AW'(pattern_pos_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q  <= '0;
			pattern_pos_q  <= '0;
			haystack_pos_q <= '0;
			gap_sum_q      <= '0;
			last_end_q     <= '0;
			first_seen_q   <= '1;
			too_long_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				pattern_len_q <= cfg_wdata;
			end
			if (proc && is_hay) begin
				if (item.haystack_last) begin
					pattern_pos_q  <= '0;
					haystack_pos_q <= '0;
					gap_sum_q      <= '0;
					last_end_q     <= '0;
					first_seen_q   <= '1;
					too_long_q     <= 1'b0;
				end else begin
					pattern_pos_q  <= pattern_pos_n;
					haystack_pos_q <= haystack_pos_n;
					gap_sum_q      <= gap_sum_n;
					last_end_q     <= last_end_n;
					first_seen_q   <= first_seen_n;
					too_long_q     <= too_long_n;
				end
			end
		end
	end

endmodule

[hw/rtl/sgs_out_fifo.sv]
module sgs_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_cnt,
	input  sgs_pkg::res_t  d0,
	input  sgs_pkg::res_t  d1,
	input  logic           out_ready,
	output logic           out_valid,
	output sgs_pkg::res_t  head,
	output logic           room
);

	sgs_pkg::res_t                  buf_q [sgs_pkg::OUT_DEPTH];
	logic [sgs_pkg::OUT_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [sgs_pkg::OUT_CNT_W-1:0]  count_q;
	logic                           pop;
	logic [sgs_pkg::OUT_PTR_W-1:0]  wr_ptr_p1;

	assign out_valid = (count_q != '0);
	assign head      = buf_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= sgs_pkg::OUT_CNT_W'(sgs_pkg::OUT_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			buf_q[wr_ptr_q] <= d0;
		end
		if (push_cnt == 2'd2) begin
			buf_q[wr_ptr_p1] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sgs_pkg::OUT_PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + sgs_pkg::OUT_CNT_W'(push_cnt) -
			           sgs_pkg::OUT_CNT_W'(pop);
		end
	end

endmodule

[hw/rtl/sgs_checker.sv]
`include "assert_macros.svh"

module sgs_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                result_kind,
	input logic [sgs_pkg::POS_W-1:0]           match_position,
	input logic signed [sgs_pkg::HPOS_W-1:0]   score,
	input logic signed [sgs_pkg::HPOS_W-1:0]   first_position,
	input logic [sgs_pkg::HPOS_W-1:0]          end_position,
	input logic                                run_last
);

	logic is_match, is_final;

	assign is_match = out_valid && (result_kind == sgs_pkg::RES_MATCH);
	assign is_final = out_valid && (result_kind == sgs_pkg::RES_FINAL);

	`SGS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(score) && $stable(match_position) && $stable(result_kind))
	`SGS_ASSERT_IMP(a_match_zero, clk, arst_n, is_match, score == '0 && first_position == '0 && end_position == '0)
	`SGS_ASSERT_IMP(a_final_last, clk, arst_n, is_final, run_last && match_position == '0)
	`SGS_ASSERT_IMP(a_miss_shape, clk, arst_n, is_final && score == '1, first_position == '1 && end_position == '0)

endmodule

bind subsequence_gap_scorer_top sgs_checker u_sgs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.result_kind    (result_kind),
	.match_position (match_position),
	.score          (score),
	.first_position (first_position),
	.end_position   (end_position),
	.run_last       (run_last)
);
